FILE: sv/sbkz_pkg.sv
// Shared types, codes and constants of the sprite blitter.
// No dependencies; every other file imports this package.
`default_nettype none

package sbkz_pkg;

    localparam int SCREEN_WIDTH   = 384;
    localparam int SCREEN_HEIGHT  = 216;
    localparam int MAX_SPRITE_DIM = 512;
    localparam int MAX_ZOOM       = 8;
    localparam int PAL_ENTRIES    = 256;
    localparam int PAL_AW         = $clog2(PAL_ENTRIES);

    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int ADDR_W  = 17;
    localparam int COLOR_W = 16;
    localparam int POS_W   = 14;   // signed screen position before clipping
    localparam int DIM_W   = 10;
    localparam int ZOOM_W  = 4;
    localparam int COL_W   = 9;

    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_BEGIN = 2'd2;

    localparam logic [2:0] CFG_DEST_X     = 3'd0;
    localparam logic [2:0] CFG_DEST_Y     = 3'd1;
    localparam logic [2:0] CFG_ROW_LENGTH = 3'd2;
    localparam logic [2:0] CFG_ROW_COUNT  = 3'd3;
    localparam logic [2:0] CFG_ZOOM       = 3'd4;
    localparam logic [2:0] CFG_MIRROR     = 3'd5;
    localparam logic [2:0] CFG_PALETTED   = 3'd6;
    localparam logic [2:0] CFG_KEY_COLOR  = 3'd7;

    typedef struct packed {
        logic signed [11:0]  dest_x;
        logic signed [11:0]  dest_y;
        logic [DIM_W-1:0]    row_length;   // clamped 1..MAX_SPRITE_DIM
        logic [DIM_W-1:0]    row_count;    // clamped 1..MAX_SPRITE_DIM
        logic [ZOOM_W-1:0]   zoom;         // clamped 1..MAX_ZOOM
        logic                mirror;
        logic                paletted;
        logic [COLOR_W-1:0]  key_color;
    } cfg_t;

    // Clipped block, never empty.
    typedef struct packed {
        logic [X_W-1:0]     x0;
        logic [X_W-1:0]     x1;
        logic [Y_W-1:0]     y0;
        logic [Y_W-1:0]     y1;
        logic [COLOR_W-1:0] color;
    } job_t;

endpackage

`default_nettype wire

FILE: sv/sbkz_front.sv
// Front end: takes requests, keeps the column/row counters and the palette,
// places and clips each pixel block. Depends on sbkz_pkg.
`default_nettype none

module sbkz_front
    import sbkz_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [1:0]         op,
    input  wire logic [15:0]        pixel_value,
    input  wire logic [7:0]         palette_index,
    input  wire logic [15:0]        palette_color,
    input  wire logic [QAW:0]       q_count,
    output logic                    push,
    output job_t                    push_job
);

    logic [COLOR_W-1:0] pal_mem [PAL_ENTRIES];
    logic [COLOR_W-1:0] pal_q_reg;

    logic [COL_W-1:0]   cc_reg, cc_next;
    logic [DIM_W-1:0]   row_reg, row_next;

    logic                    s1_v_reg, s1_v_next;
    logic signed [POS_W-1:0] s1_colz_reg;
    logic signed [POS_W-1:0] s1_rowz_reg;
    logic [COLOR_W-1:0]      s1_pv_reg;

    logic                    acc;
    logic                    is_pixel;
    logic                    in_rows;
    logic [DIM_W-1:0]        cc_inc;
    logic signed [10:0]      col;
    logic signed [POS_W-1:0] col_ext;
    logic signed [POS_W-1:0] zoom_ext;
    logic signed [POS_W-1:0] colz;
    logic signed [POS_W-1:0] rowz;

    logic [COLOR_W-1:0]      color;
    logic signed [POS_W-1:0] zm1;
    logic signed [POS_W-1:0] bx, bxe, by, bye;
    logic                    x_on, y_on;

    localparam logic signed [POS_W-1:0] SCR_W_S = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] SCR_H_S = POS_W'(SCREEN_HEIGHT);

    // A slot is held for every pixel in flight so the queue never overflows.
    assign item_stall = ({1'b0, q_count} + {{(QAW + 1){1'b0}}, s1_v_reg})
                        >= (QAW + 2)'(QDEPTH);
    assign acc        = item_valid && !item_stall;
    assign is_pixel   = (op == OP_PIXEL);
    assign in_rows    = row_reg < cfg.row_count;
    assign cc_inc     = {1'b0, cc_reg} + DIM_W'(1);

    always_comb
    begin
        if (cfg.mirror)
        begin
            col = $signed({1'b0, cfg.row_length}) - 11'sd1 - $signed({2'b00, cc_reg});
        end
        else
        begin
            col = $signed({2'b00, cc_reg});
        end
        col_ext  = $signed({{(POS_W-11){col[10]}}, col});
        zoom_ext = $signed({{(POS_W-ZOOM_W){1'b0}}, cfg.zoom});
        colz     = col_ext * zoom_ext;
        rowz     = $signed({{(POS_W-DIM_W){1'b0}}, row_reg}) * zoom_ext;
    end

    always_comb
    begin
        cc_next   = cc_reg;
        row_next  = row_reg;
        s1_v_next = 1'b0;
        if (acc)
        begin
            if (op == OP_BEGIN)
            begin
                cc_next  = '0;
                row_next = '0;
            end
            else if (is_pixel && in_rows)
            begin
                s1_v_next = 1'b1;
                if (cc_inc >= cfg.row_length)
                begin
                    cc_next  = '0;
                    row_next = row_reg + DIM_W'(1);
                end
                else
                begin
                    cc_next = cc_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg   <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
        end
        else
        begin
            cc_reg   <= cc_next;
            row_reg  <= row_next;
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && (op == OP_LOAD))
        begin
            pal_mem[palette_index[PAL_AW-1:0]] <= palette_color;
        end
        if (acc)
        begin
            pal_q_reg <= pal_mem[pixel_value[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_next)
        begin
            s1_colz_reg <= colz;
            s1_rowz_reg <= rowz;
            s1_pv_reg   <= pixel_value;
        end
    end

    // Stage 2: block position, clip window and key test.
    always_comb
    begin
        color = cfg.paletted ? pal_q_reg : s1_pv_reg;
        zm1   = $signed({{(POS_W-ZOOM_W){1'b0}}, cfg.zoom - ZOOM_W'(1)});
        bx    = $signed({{(POS_W-12){cfg.dest_x[11]}}, cfg.dest_x}) + s1_colz_reg;
        by    = $signed({{(POS_W-12){cfg.dest_y[11]}}, cfg.dest_y}) + s1_rowz_reg;
        bxe   = bx + zm1;
        bye   = by + zm1;
        x_on  = (bxe >= 0) && (bx < SCR_W_S);
        y_on  = (bye >= 0) && (by < SCR_H_S);

        push_job.x0 = bx[POS_W-1] ? '0 : bx[X_W-1:0];
        push_job.x1 = (bxe >= SCR_W_S) ? X_W'(SCREEN_WIDTH - 1) : bxe[X_W-1:0];
        push_job.y0 = by[POS_W-1] ? '0 : by[Y_W-1:0];
        push_job.y1 = (bye >= SCR_H_S) ? Y_W'(SCREEN_HEIGHT - 1) : bye[Y_W-1:0];
        push_job.color = color;

        push = s1_v_reg && (color != cfg.key_color) && x_on && y_on;
    end

endmodule

`default_nettype wire

FILE: sv/sbkz_queue.sv
// Short job queue between the front end and the write generator.
// Depends on sbkz_pkg.
`default_nettype none

module sbkz_queue
    import sbkz_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire job_t         push_job,
    input  wire logic         pop,
    output job_t              head,
    output logic              not_empty,
    output logic [QAW:0]      count
);

    job_t               mem [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]       count_reg, count_next;
    logic               do_pop;

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW + 1)'(push) - (QAW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sbkz_back.sv
// Back end: walks each clipped block column by column, one framebuffer
// write per cycle while write_stall is low, into the output register. Depends on sbkz_pkg.
`default_nettype none

module sbkz_back
    import sbkz_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire job_t                head,
    input  wire logic                not_empty,
    output logic                     pop,
    output logic                     write_valid,
    input  wire logic                write_stall,
    output logic [X_W-1:0]           write_x,
    output logic [Y_W-1:0]           write_y,
    output logic [ADDR_W-1:0]        write_address,
    output logic [COLOR_W-1:0]       write_color,
    output logic                     last
);

    logic               act_reg, act_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic [Y_W-1:0]     y_reg, y_next;
    logic [X_W-1:0]     x1_reg, x1_next;
    logic [Y_W-1:0]     y0_reg, y0_next;
    logic [Y_W-1:0]     y1_reg, y1_next;
    logic [COLOR_W-1:0] color_reg, color_next;

    logic               out_v_reg, out_v_next;
    logic [X_W-1:0]     ox_reg;
    logic [Y_W-1:0]     oy_reg;
    logic [ADDR_W-1:0]  oaddr_reg;
    logic [COLOR_W-1:0] ocolor_reg;
    logic               olast_reg;

    logic               load_out, emit, cur_last;
    logic [X_W-1:0]     cx, cx1;
    logic [Y_W-1:0]     cy, cy0, cy1;
    logic [COLOR_W-1:0] ccolor;
    logic [ADDR_W-1:0]  caddr;

    assign load_out = !out_v_reg || !write_stall;
    assign emit     = load_out && (act_reg || not_empty);
    assign pop      = emit && !act_reg;

    always_comb
    begin
        if (act_reg)
        begin
            cx     = x_reg;
            cy     = y_reg;
            cx1    = x1_reg;
            cy0    = y0_reg;
            cy1    = y1_reg;
            ccolor = color_reg;
        end
        else
        begin
            cx     = head.x0;
            cy     = head.y0;
            cx1    = head.x1;
            cy0    = head.y0;
            cy1    = head.y1;
            ccolor = head.color;
        end
        cur_last = (cx == cx1) && (cy == cy1);
        caddr    = ADDR_W'(cx) + ADDR_W'(ADDR_W'(SCREEN_WIDTH) * ADDR_W'(cy));

        act_next   = act_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        x1_next    = cx1;
        y0_next    = cy0;
        y1_next    = cy1;
        color_next = ccolor;
        out_v_next = out_v_reg && write_stall;
        if (emit)
        begin
            out_v_next = 1'b1;
            act_next   = !cur_last;
            if (cy == cy1)
            begin
                x_next = cx + X_W'(1);
                y_next = cy0;
            end
            else
            begin
                x_next = cx;
                y_next = cy + Y_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            act_reg   <= act_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            x1_reg     <= x1_next;
            y0_reg     <= y0_next;
            y1_reg     <= y1_next;
            color_reg  <= color_next;
            ox_reg     <= cx;
            oy_reg     <= cy;
            oaddr_reg  <= caddr;
            ocolor_reg <= ccolor;
            olast_reg  <= cur_last;
        end
    end

    assign write_valid   = out_v_reg;
    assign write_x       = ox_reg;
    assign write_y       = oy_reg;
    assign write_address = oaddr_reg;
    assign write_color   = ocolor_reg;
    assign last          = olast_reg;

endmodule

`default_nettype wire

FILE: sv/sprite_blitter_clip_key_zoom_core.sv
// Sprite blitter with color key, clipping at the left, right, top and bottom of the screen, mirror and zoom.
// Top level: configuration registers, front end, job queue, back end.
// Depends on sbkz_pkg, sbkz_front, sbkz_queue, sbkz_back.
//
// Rate: a request is taken every cycle while the job queue has room. Each
// source pixel that survives clipping and the key test gives up to zoom
// squared framebuffer writes, one per cycle while write_stall is low (the
// back end's single write port); pixels with no writes, palette loads and
// begin-sprite requests cost nothing there. A request passes the front end's
// stage-1 register, the job queue and the output register before its first
// write. The palette read is registered; a load is seen by the very next pixel.
`default_nettype none

module sprite_blitter_clip_key_zoom_core
    import sbkz_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic [1:0]          op,
    input  wire logic [15:0]         pixel_value,
    input  wire logic [7:0]          palette_index,
    input  wire logic [15:0]         palette_color,
    output logic                     write_valid,
    input  wire logic                write_stall,
    output logic [X_W-1:0]           write_x,
    output logic [Y_W-1:0]           write_y,
    output logic [ADDR_W-1:0]        write_address,
    output logic [COLOR_W-1:0]       write_color,
    output logic                     last
);

    cfg_t           cfg_reg, cfg_next;
    logic           push, pop, not_empty;
    job_t           push_job, head;
    logic [QAW:0]   q_count;
    logic [DIM_W-1:0]  dim_raw, dim_clamp;
    logic [ZOOM_W-1:0] zoom_raw, zoom_clamp;

    always_comb
    begin
        dim_raw  = cfg_data[DIM_W-1:0];
        zoom_raw = cfg_data[ZOOM_W-1:0];
        if (dim_raw == '0)
        begin
            dim_clamp = DIM_W'(1);
        end
        else if (dim_raw > DIM_W'(MAX_SPRITE_DIM))
        begin
            dim_clamp = DIM_W'(MAX_SPRITE_DIM);
        end
        else
        begin
            dim_clamp = dim_raw;
        end
        if (zoom_raw == '0)
        begin
            zoom_clamp = ZOOM_W'(1);
        end
        else if (zoom_raw > ZOOM_W'(MAX_ZOOM))
        begin
            zoom_clamp = ZOOM_W'(MAX_ZOOM);
        end
        else
        begin
            zoom_clamp = zoom_raw;
        end

        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEST_X:     cfg_next.dest_x     = $signed(cfg_data[11:0]);
                CFG_DEST_Y:     cfg_next.dest_y     = $signed(cfg_data[11:0]);
                CFG_ROW_LENGTH: cfg_next.row_length = dim_clamp;
                CFG_ROW_COUNT:  cfg_next.row_count  = dim_clamp;
                CFG_ZOOM:       cfg_next.zoom       = zoom_clamp;
                CFG_MIRROR:     cfg_next.mirror     = cfg_data[0];
                CFG_PALETTED:   cfg_next.paletted   = cfg_data[0];
                CFG_KEY_COLOR:  cfg_next.key_color  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_x     <= '0;
            cfg_reg.dest_y     <= '0;
            cfg_reg.row_length <= DIM_W'(1);
            cfg_reg.row_count  <= DIM_W'(1);
            cfg_reg.zoom       <= ZOOM_W'(1);
            cfg_reg.mirror     <= 1'b0;
            cfg_reg.paletted   <= 1'b0;
            cfg_reg.key_color  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbkz_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .pixel_value   (pixel_value),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .q_count       (q_count),
        .push          (push),
        .push_job      (push_job)
    );

    sbkz_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    sbkz_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .not_empty     (not_empty),
        .pop           (pop),
        .write_valid   (write_valid),
        .write_stall   (write_stall),
        .write_x       (write_x),
        .write_y       (write_y),
        .write_address (write_address),
        .write_color   (write_color),
        .last          (last)
    );

endmodule

`default_nettype wire

FILE: sv/sbkz_checker.sv
// Port-level checks for the sprite blitter, bound to the top level.
// Depends on sbkz_pkg and sprite_blitter_clip_key_zoom_core.
`default_nettype none

module sbkz_checker
    import sbkz_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                write_valid,
    input  wire logic                write_stall,
    input  wire logic [X_W-1:0]      write_x,
    input  wire logic [Y_W-1:0]      write_y,
    input  wire logic [ADDR_W-1:0]   write_address,
    input  wire logic [COLOR_W-1:0]  write_color,
    input  wire logic                last
);

    logic [ADDR_W-1:0] exp_addr;

    assign exp_addr = ADDR_W'(write_x) + ADDR_W'(ADDR_W'(SCREEN_WIDTH) * ADDR_W'(write_y));

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && write_stall |=> write_valid
            && $stable({write_x, write_y, write_address, write_color, last}))
        else $error("stalled write request changed");

    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid |-> (write_x < X_W'(SCREEN_WIDTH)) && (write_y < Y_W'(SCREEN_HEIGHT)))
        else $error("write outside the screen");

    a_address: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid |-> write_address == exp_addr)
        else $error("write address does not match x and y");

    a_block_burst: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && !write_stall && !last |=> write_valid)
        else $error("gap inside a pixel block");

endmodule

bind sprite_blitter_clip_key_zoom_core sbkz_checker u_sbkz_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .write_valid   (write_valid),
    .write_stall   (write_stall),
    .write_x       (write_x),
    .write_y       (write_y),
    .write_address (write_address),
    .write_color   (write_color),
    .last          (last)
);

`default_nettype wire

FILE: tb/sv/tb_sprite_blitter_clip_key_zoom_core.sv
// Self-checking testbench for sprite_blitter_clip_key_zoom_core: directed and random requests,
// a cycle-free predictor of framebuffer writes, and in-order checking of every accepted write.
// Depends on sbkz_pkg and the blitter RTL only.
module tb_sprite_blitter_clip_key_zoom_core;
    import sbkz_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } fb_write_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  op;
    logic [15:0] pixel_value;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic        write_valid;
    logic        write_stall = 1'b0;
    logic [X_W-1:0]     write_x;
    logic [Y_W-1:0]     write_y;
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] write_color;
    logic        last;

    // predictor copy of the registers and counters
    logic [11:0]  reg_dest_x = '0;
    logic [11:0]  reg_dest_y = '0;
    logic [9:0]   reg_row_len = 10'd1;
    logic [9:0]   reg_row_count = 10'd1;
    logic [3:0]   reg_zoom = 4'd1;
    logic         reg_mirror = 1'b0;
    logic         reg_paletted = 1'b0;
    logic [15:0]  reg_key = '0;
    logic [8:0]   col_cnt = '0;
    logic [9:0]   row_idx = '0;
    logic [15:0]  pal_entries [PAL_ENTRIES];
    logic [7:0]   loaded_idx [$];

    fb_write_t pending_writes [$];
    fb_write_t want_w;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int stall_hold = 0;
    int items_sent = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    sprite_blitter_clip_key_zoom_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .pixel_value   (pixel_value),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .write_valid   (write_valid),
        .write_stall   (write_stall),
        .write_x       (write_x),
        .write_y       (write_y),
        .write_address (write_address),
        .write_color   (write_color),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void compute_writes(logic [1:0] req_op, logic [15:0] pv,
                                           logic [7:0] pidx, logic [15:0] pcol);
        int len, rows, z, col, bx, by, a, b;
        logic [15:0] color;
        fb_write_t w, held;
        bit have_held;
        have_held = 0;
        case (req_op)
            OP_LOAD:
            begin
                pal_entries[pidx] = pcol;
                loaded_idx.push_back(pidx);
            end
            OP_BEGIN:
            begin
                col_cnt = '0;
                row_idx = '0;
            end
            OP_PIXEL:
            begin
                len = clamp_dim(int'(reg_row_len), MAX_SPRITE_DIM);
                rows = clamp_dim(int'(reg_row_count), MAX_SPRITE_DIM);
                z = clamp_dim(int'(reg_zoom), MAX_ZOOM);
                if (int'(row_idx) < rows)
                begin
                    color = reg_paletted ? pal_entries[pv[7:0]] : pv;
                    col = reg_mirror ? len - 1 - int'(col_cnt) : int'(col_cnt);
                    bx = int'($signed(reg_dest_x)) + col * z;
                    by = int'($signed(reg_dest_y)) + int'(row_idx) * z;
                    if (color != reg_key)
                    begin
                        for (int tx = 0; tx < z; tx++)
                        begin
                            a = bx + tx;
                            if (a < 0 || a >= SCREEN_WIDTH)
                                continue;
                            for (int ty = 0; ty < z; ty++)
                            begin
                                b = by + ty;
                                if (b < 0 || b >= SCREEN_HEIGHT)
                                    continue;
                                w.x = a[X_W-1:0];
                                w.y = b[Y_W-1:0];
                                w.addr = ADDR_W'(a + SCREEN_WIDTH * b);
                                w.color = color;
                                w.last = 1'b0;
                                if (have_held)
                                    pending_writes.push_back(held);
                                held = w;
                                have_held = 1;
                            end
                        end
                    end
                    if (have_held)
                    begin
                        held.last = 1'b1;
                        pending_writes.push_back(held);
                    end
                    if (int'(col_cnt) + 1 >= len)
                    begin
                        col_cnt = '0;
                        row_idx = row_idx + 10'd1;
                    end
                    else
                        col_cnt = col_cnt + 9'd1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_req(input logic [1:0] o, input logic [15:0] pv,
                            input logic [7:0] pi, input logic [15:0] pc);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        op <= o;
        pixel_value <= pv;
        palette_index <= pi;
        palette_color <= pc;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        compute_writes(o, pv, pi, pc);
        if (o != OP_UNUSED)
            items_sent++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_DEST_X:     reg_dest_x = val[11:0];
            CFG_DEST_Y:     reg_dest_y = val[11:0];
            CFG_ROW_LENGTH: reg_row_len = val[9:0];
            CFG_ROW_COUNT:  reg_row_count = val[9:0];
            CFG_ZOOM:       reg_zoom = val[3:0];
            CFG_MIRROR:     reg_mirror = val[0];
            CFG_PALETTED:   reg_paletted = val[0];
            CFG_KEY_COLOR:  reg_key = val;
            default: ;
        endcase
    endtask

    task automatic set_sprite(input int dx, input int dy, input int len, input int rows,
                              input int z, input bit mir, input bit pal,
                              input logic [15:0] key);
        wait_idle();
        write_reg(CFG_DEST_X, 16'(dx));
        write_reg(CFG_DEST_Y, 16'(dy));
        write_reg(CFG_ROW_LENGTH, 16'(len));
        write_reg(CFG_ROW_COUNT, 16'(rows));
        write_reg(CFG_ZOOM, 16'(z));
        write_reg(CFG_MIRROR, {15'd0, mir});
        write_reg(CFG_PALETTED, {15'd0, pal});
        write_reg(CFG_KEY_COLOR, key);
    endtask

    // registers still at reset values
    task automatic test_reset_defaults();
        send_req(OP_PIXEL, 16'hFFFF, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h1234, 8'hFF, 16'hFFFF);   // beyond row count
        send_req(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h0000, 8'h00, 16'h0000);   // key color
    endtask

    task automatic test_palette_mirror();
        send_req(OP_LOAD, 16'h0000, 8'h00, 16'h8001);
        send_req(OP_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF);
        set_sprite(100, 50, 4, 1, 1, 1'b1, 1'b1, 16'hFFFF);
        send_req(OP_BEGIN, 16'h5555, 8'hAA, 16'h5555);
        send_req(OP_PIXEL, 16'hAB00, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h12FF, 8'h00, 16'h0000);
        send_req(OP_LOAD, 16'h0000, 8'h00, 16'h07E0);
        send_req(OP_PIXEL, 16'hFF00, 8'h00, 16'h0000);   // sees the reload
    endtask

    task automatic test_clip_zoom();
        set_sprite(380, 212, 2, 1, 8, 1'b0, 1'b0, 16'h0000);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'hF800, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'hF800, 8'h00, 16'h0000);
        set_sprite(-5, -6, 2, 1, 15, 1'b0, 1'b0, 16'h0000);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h001F, 8'h00, 16'h0000);
        set_sprite(-500, 0, 1023, 1023, 0, 1'b1, 1'b0, 16'h0001);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h7BEF, 8'h00, 16'h0000);
        set_sprite(2047, -2048, 0, 0, 1, 1'b0, 1'b0, 16'h0000);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h7BEF, 8'h00, 16'h0000);
        set_sprite(-2048, 2047, 1, 1, 8, 1'b0, 1'b0, 16'h0000);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h7BEF, 8'h00, 16'h0000);
    endtask

    // row length shrinks below the current column in mid-row
    task automatic test_short_row();
        set_sprite(20, 30, 8, 2, 1, 1'b0, 1'b0, 16'h0000);
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        repeat (3) send_req(OP_PIXEL, 16'h1111, 8'h00, 16'h0000);
        wait_idle();
        write_reg(CFG_ROW_LENGTH, 16'd2);
        write_reg(CFG_MIRROR, 16'd1);
        send_req(OP_PIXEL, 16'h2222, 8'h00, 16'h0000);
        send_req(OP_PIXEL, 16'h3333, 8'h00, 16'h0000);
    endtask

    // receiver holds off while requests keep coming, then the queued writes drain
    task automatic test_backpressure();
        set_sprite(10, 10, 8, 2, 2, 1'b0, 1'b0, 16'h0000);
        send_gap_pct = 0;
        stall_pct = 0;
        stall_hold = 200;
        send_req(OP_BEGIN, 16'h0000, 8'h00, 16'h0000);
        repeat (16) send_req(OP_PIXEL, 16'($urandom) | 16'h0001, 8'($urandom), 16'($urandom));
        wait_idle();
    endtask

    task automatic random_sprite();
        int dx, dy, len, rows, z, npix;
        bit mir, pal;
        logic [15:0] key, pv;
        logic [15:0] colors [4];
        dx = ($urandom_range(9) == 0) ? int'($urandom_range(4095)) - 2048
                                      : int'($urandom_range(430)) - 30;
        dy = ($urandom_range(9) == 0) ? int'($urandom_range(4095)) - 2048
                                      : int'($urandom_range(260)) - 30;
        len = ($urandom_range(9) == 0) ? int'($urandom_range(1023)) : int'($urandom_range(1, 6));
        rows = ($urandom_range(9) == 0) ? int'($urandom_range(1023)) : int'($urandom_range(1, 4));
        z = ($urandom_range(9) == 0) ? int'($urandom_range(15)) : int'($urandom_range(1, 4));
        mir = 1'($urandom_range(1));
        pal = 1'($urandom_range(1));
        for (int k = 0; k < 4; k++)
            colors[k] = 16'($urandom);
        case ($urandom_range(2))
            0: key = pal ? pal_entries[loaded_idx[$urandom_range(loaded_idx.size() - 1)]]
                         : colors[0];
            1: key = 16'($urandom);
            default: key = 16'h0000;
        endcase
        set_sprite(dx, dy, len, rows, z, mir, pal, key);
        send_req(OP_BEGIN, 16'($urandom), 8'($urandom), 16'($urandom));
        npix = clamp_dim(len, MAX_SPRITE_DIM) * clamp_dim(rows, MAX_SPRITE_DIM);
        npix = (npix > 24 ? 24 : npix) + int'($urandom_range(2));
        for (int k = 0; k < npix; k++)
        begin
            if ($urandom_range(14) == 0)
                send_req(OP_LOAD, 16'($urandom), 8'($urandom), 16'($urandom));
            if ($urandom_range(24) == 0)
                send_req(OP_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom));
            if (pal)
                pv = {8'($urandom), loaded_idx[$urandom_range(loaded_idx.size() - 1)]};
            else if ($urandom_range(3) != 0)
                pv = colors[$urandom_range(3)];
            else
                pv = 16'($urandom);
            send_req(OP_PIXEL, pv, 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random(input int gap, input int stall, input int quota);
        int start;
        start = items_sent;
        send_gap_pct = gap;
        stall_pct = stall;
        while (items_sent - start < quota)
            random_sprite();
    endtask

    // write checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && write_valid && !write_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: x %0d y %0d color %h", write_x, write_y, write_color);
                mismatch_count++;
            end
            else
            begin
                want_w = pending_writes.pop_front();
                if (write_x !== want_w.x)
                begin
                    $error("write_x: expected %0d, actual %0d", want_w.x, write_x);
                    mismatch_count++;
                end
                if (write_y !== want_w.y)
                begin
                    $error("write_y: expected %0d, actual %0d", want_w.y, write_y);
                    mismatch_count++;
                end
                if (write_address !== want_w.addr)
                begin
                    $error("write_address: expected %0d, actual %0d", want_w.addr, write_address);
                    mismatch_count++;
                end
                if (write_color !== want_w.color)
                begin
                    $error("write_color: expected %h, actual %h", want_w.color, write_color);
                    mismatch_count++;
                end
                if (last !== want_w.last)
                begin
                    $error("last: expected %0d, actual %0d", want_w.last, last);
                    mismatch_count++;
                end
            end
        end
        if (stall_hold > 0)
        begin
            write_stall <= 1'b1;
            stall_hold--;
        end
        else
            write_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (write_valid && !write_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_DEST_X;
        cfg_data = '0;
        item_valid = 1'b0;
        op = OP_LOAD;
        pixel_value = '0;
        palette_index = '0;
        palette_color = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_palette_mirror();
        test_clip_zoom();
        test_short_row();
        test_backpressure();
        test_random(0, 0, 10);
        test_random(59, 0, 10);
        test_random(0, 59, 10);
        test_random(29, 29, 10);
        wait_idle();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
